### hdl/srs_pkg.sv
// Shared types and constants of the streaming substring replacer.
`timescale 1ns / 1ps

package srs_pkg;

    // Bytes in the pattern and replacement registers, and the widest window.
    localparam int HOLD = 8;
    localparam int BYTE_W = 8;
    localparam int REG_W = HOLD * BYTE_W;
    localparam int LEN_W = 4;
    localparam int CNT_W = 4;
    localparam int IDX_W = 3;
    localparam int REPORT_W = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              string_end;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                byte_present;
        logic                run_last;
        logic                output_end;
        logic [REPORT_W-1:0] matches_found;
    } t_result;

    // One input item's worth of work for the back end: up to HOLD bytes to
    // send, the byte count (zero with an end flag means a bare end marker).
    typedef struct packed {
        logic [HOLD-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]            count;
        logic                        str_end;
        logic [REPORT_W-1:0]         match_count;
    } t_cmd;

endpackage

### hdl/srs_front.sv
// Front end: configuration, match window, pattern compare and match tally.
`timescale 1ns / 1ps

module srs_front import srs_pkg::*; #(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_REPLACEMENT = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]       i_cfg_data,
    input  logic                   i_accept,
    input  t_in_item               i_item,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    localparam int WIN = (MAX_PATTERN < HOLD) ? MAX_PATTERN : HOLD;
    localparam int RMAX = (MAX_REPLACEMENT < HOLD) ? MAX_REPLACEMENT : HOLD;
    localparam int FILL_W = $clog2(WIN + 1);

    logic [REG_W-1:0]        r_pat_bytes;
    logic [LEN_W-1:0]        r_pat_len;
    logic [REG_W-1:0]        r_rep_bytes;
    logic [LEN_W-1:0]        r_rep_len;
    logic [WIN-1:0][BYTE_W-1:0] r_win, n_win;
    logic [FILL_W-1:0]       r_fill, n_fill;
    logic [COUNT_WIDTH-1:0]  r_tally, n_tally;

    logic [LEN_W-1:0]        plen, rlen;
    logic [WIN-1:0][BYTE_W-1:0] w_ext;
    logic                    passthru, full, hit;
    logic [COUNT_WIDTH-1:0]  tally_new;
    logic [63:0]             tally_ext;
    logic [REPORT_W-1:0]     report;

    always_comb begin
        plen = (r_pat_len > LEN_W'(WIN)) ? LEN_W'(WIN) : r_pat_len;
        rlen = (r_rep_len > LEN_W'(RMAX)) ? LEN_W'(RMAX) : r_rep_len;
        passthru = (plen == '0);
        // Window with the new byte appended at the fill position.
        for (int i = 0; i < WIN; i++) begin
            w_ext[i] = (FILL_W'(i) == r_fill) ? i_item.in_byte : r_win[i];
        end
        full = !passthru && ((LEN_W'(r_fill) + LEN_W'(1)) == plen);
        hit = full;
        for (int i = 0; i < WIN; i++) begin
            if ((LEN_W'(i) < plen) && (w_ext[i] != r_pat_bytes[BYTE_W*i +: BYTE_W])) begin
                hit = 1'b0;
            end
        end
        if (hit && (r_tally != '1)) begin
            tally_new = r_tally + COUNT_WIDTH'(1);
        end else begin
            tally_new = r_tally;
        end
        tally_ext = 64'(tally_new);
        report = (tally_ext > 64'(32'hFFFF_FFFF)) ? '1 : tally_ext[REPORT_W-1:0];
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.str_end = i_item.string_end;
        o_cmd.match_count = i_item.string_end ? report : '0;
        if (passthru) begin
            o_cmd.bytes[0] = i_item.in_byte;
            o_cmd.count = CNT_W'(1);
        end else if (hit) begin
            for (int i = 0; i < HOLD; i++) begin
                o_cmd.bytes[i] = r_rep_bytes[BYTE_W*i +: BYTE_W];
            end
            o_cmd.count = CNT_W'(rlen);
        end else begin
            for (int i = 0; i < WIN; i++) begin
                o_cmd.bytes[i] = w_ext[i];
            end
            if (i_item.string_end) begin
                o_cmd.count = CNT_W'(r_fill) + CNT_W'(1);
            end else if (full) begin
                o_cmd.count = CNT_W'(1);
            end else begin
                o_cmd.count = '0;
            end
        end
        o_push = i_accept && ((o_cmd.count != '0) || i_item.string_end);
    end

    always_comb begin
        n_win = r_win;
        n_fill = r_fill;
        n_tally = r_tally;
        if (i_accept) begin
            n_win = w_ext;
            n_tally = i_item.string_end ? '0 : tally_new;
            if (passthru || hit || i_item.string_end) begin
                n_fill = '0;
            end else if (full) begin
                // Oldest byte leaves; the rest move up one place.
                for (int i = 0; i < WIN - 1; i++) begin
                    n_win[i] = w_ext[i+1];
                end
            end else begin
                n_fill = r_fill + FILL_W'(1);
            end
        end
        if (i_cfg_we && (t_reg_index'(i_cfg_index) == REG_PATTERN_LENGTH)) begin
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len <= '0;
            r_rep_bytes <= '0;
            r_rep_len <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_PATTERN_BYTES:      r_pat_bytes <= i_cfg_data;
                REG_PATTERN_LENGTH:     r_pat_len <= i_cfg_data[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  r_rep_bytes <= i_cfg_data;
                REG_REPLACEMENT_LENGTH: r_rep_len <= i_cfg_data[LEN_W-1:0];
                default:                r_pat_len <= r_pat_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_tally <= '0;
        end else begin
            r_fill <= n_fill;
            r_tally <= n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

### hdl/srs_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module srs_queue import srs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_count;

    assign o_full = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

endmodule

### hdl/srs_back.sv
// Back end: expands each command into result transfers through an output register.
`timescale 1ns / 1ps

module srs_back import srs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_head,
    input  logic    i_head_valid,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_res
);

    logic [IDX_W-1:0] r_k;
    logic             r_out_valid;
    t_result          r_res, n_res;
    logic             bare, last_res, load;

    always_comb begin
        bare = (i_head.count == '0);
        last_res = bare || ((CNT_W'(r_k) + CNT_W'(1)) == i_head.count);
        load = i_head_valid && (!r_out_valid || i_pop);
        n_res.out_byte = bare ? '0 : i_head.bytes[r_k];
        n_res.byte_present = !bare;
        n_res.run_last = last_res;
        n_res.output_end = last_res && i_head.str_end;
        n_res.matches_found = (last_res && i_head.str_end) ? i_head.match_count : '0;
        o_q_pop = load && last_res;
    end

    assign o_empty = !r_out_valid;
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_k <= last_res ? '0 : r_k + IDX_W'(1);
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

endmodule

### hdl/substring_replace_stream.sv
// Top level of the streaming substring find-and-replace block.
`timescale 1ns / 1ps

// Channel   | Handshake            | Payload
// ----------+----------------------+------------------------------------------
// input     | push / full          | i_item  : in_byte, string_end
// result    | empty / pop          | o_result: out_byte, byte_present, run_last,
//           |                      |           output_end, matches_found
// config    | i_cfg_we             | i_cfg_index, i_cfg_data
//
// One input byte is taken per cycle while the command queue has room; each
// byte yields zero to eight result transfers, and the back end sends one
// result per cycle while the result side keeps popping.
// A result passes through the command queue and then the output register.
// Reset is synchronous and active low; it clears configuration, fill, tally, queue and output.
// A stalled result side fills the four-entry queue, after which full rises.

module substring_replace_stream import srs_pkg::*; #(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_REPLACEMENT = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]       i_cfg_data,
    input  logic                   push,
    output logic                   full,
    input  t_in_item               i_item,
    output logic                   empty,
    input  logic                   pop,
    output t_result                o_result
);

    logic accept;
    logic q_push, q_pop, q_full, q_empty;
    t_cmd front_cmd, q_head;

    // The queue full flag is the input-side stall; everything else flows.
    assign full = q_full;
    assign accept = push && !q_full;

    // The front end classifies each byte: pass through, hit, shift or hold.
    srs_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_push      (q_push),
        .o_cmd       (front_cmd)
    );

    // Commands that cause no result are never queued.
    srs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // The back end walks each command one byte per transfer.
    srs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_head_valid (!q_empty),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_res        (o_result)
    );

    // A result without a byte is only ever the end marker of a string.
    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.byte_present) |-> o_result.output_end)
        else $error("bare result that does not end the string");

    // The match count is reported on the final result of a string only.
    a_count_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.output_end) |-> (o_result.matches_found == '0))
        else $error("match count outside the end of a string");

    // With nothing queued and nothing arriving, no result can appear.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_empty && empty && !q_push) |=> empty)
        else $error("result appeared with no queued work");

endmodule
